FILE: design/htd_pkg.sv
// Shared types and constants for the hot trace head detector.
// Used by htd_cell and by the top level hot_trace_head_detector.
`default_nettype none

package htd_pkg;

    localparam int ADDR_W              = 64;
    localparam int THRESH_W            = 16;
    localparam int TABLE_ENTRIES_DEF   = 64;
    localparam int COUNT_BITS_DEF      = 16;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd50;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    // Control broadcast from the top level to every cell of the table.
    typedef struct packed {
        logic capture;   // a transaction is accepted this cycle
        logic count_it;  // the accepted target is to be counted
        logic commit;    // the captured lookup is written back this cycle
        logic insert;    // counted target missed: the first free cell takes it
        logic thr_zero;  // threshold is zero, so a new entry fires at once
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: design/htd_cell.sv
// One table entry of the hot trace head detector: address, hit counter and flags.
// Depends on htd_pkg; cells form a chain through their valid bits.
`default_nettype none

module htd_cell
    import htd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire logic [ADDR_W-1:0]   i_new_addr,
    input  wire logic [ADDR_W-1:0]   i_upd_addr,
    input  wire logic [THRESH_W-1:0] i_threshold,
    input  wire logic                i_prev_valid,
    output logic                     o_valid,
    output logic                     o_hit,
    output logic                     o_fire
);

    localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

    logic                  r_valid;
    logic [ADDR_W-1:0]     r_addr;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_made;
    logic                  r_hit;
    logic                  r_fire;
    logic                  r_count_it;

    logic                  n_hit;
    logic [COUNT_BITS-1:0] n_count_sat;
    logic [COUNT_BITS-1:0] n_count_eval;
    logic                  n_fire;
    logic                  n_take;

    always_comb begin
        n_hit        = r_valid && (r_addr == i_new_addr);
        n_count_sat  = (r_count == '1) ? r_count : r_count + COUNT_BITS'(1);
        n_count_eval = i_ctrl.count_it ? n_count_sat : r_count;
        n_fire       = n_hit && !r_made
                       && (CMP_W'(n_count_eval) >= CMP_W'(i_threshold));
        // Entries fill from the bottom, so the first free cell is the one whose
        // lower neighbour is already taken.
        n_take       = i_ctrl.commit && i_ctrl.insert && i_prev_valid && !r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_made     <= 1'b0;
            r_count    <= '0;
            r_hit      <= 1'b0;
            r_fire     <= 1'b0;
            r_count_it <= 1'b0;
        end else begin
            if (i_ctrl.capture) begin
                r_hit      <= n_hit;
                r_fire     <= n_fire;
                r_count_it <= i_ctrl.count_it;
            end
            if (i_ctrl.commit) begin
                if (r_hit) begin
                    if (r_count_it) begin
                        r_count <= n_count_sat;
                    end
                    if (r_fire) begin
                        r_made <= 1'b1;
                    end
                end else if (n_take) begin
                    r_valid <= 1'b1;
                    r_count <= '0;
                    r_made  <= i_ctrl.thr_zero;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take) begin
            r_addr <= i_upd_addr;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;
    assign o_fire  = r_fire;

endmodule

`default_nettype wire

FILE: design/hot_trace_head_detector.sv
// Top level of the hot trace head detector: handshakes, threshold and the cell chain.
// Depends on htd_pkg and htd_cell.
`default_nettype none

// When a transaction is accepted every cell compares its address with the target and
// works out whether it would fire; in ST_UPDATE, once the output register is free, the
// row of cells writes back the count, the region flag or a new entry, and the result
// goes to the output register. A new transaction is taken only once that write-back is
// done, so the detector does not accept a new branch while one is still in flight.
// Entries fill from the lowest slot and are never removed; once all slots are taken a
// counted unknown target is reported through table_full. Reset clears the whole
// table at once, with no clearing pass.
module hot_trace_head_detector
    import htd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [THRESH_W-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_func,
    input  wire logic [ADDR_W-1:0]   i_cur_addr,
    input  wire logic [ADDR_W-1:0]   i_new_addr,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_start_recording,
    output logic [ADDR_W-1:0]        o_start_addr,
    output logic                     o_table_full
);

    t_state                  r_state;
    t_state                  n_state;
    logic [THRESH_W-1:0]     r_threshold;
    logic [ADDR_W-1:0]       r_new_addr;
    logic                    r_count_it;
    logic                    r_out_valid;
    logic                    r_start;
    logic [ADDR_W-1:0]       r_start_addr;
    logic                    r_full;

    logic                    accept;
    logic                    commit;
    logic                    out_free;
    logic                    count_now;
    logic                    any_hit;
    logic                    any_fire;
    logic                    table_is_full;
    logic                    n_start;
    logic                    n_full;
    t_cell_ctrl              ctrl;

    logic [TABLE_ENTRIES-1:0] cell_valid;
    logic [TABLE_ENTRIES-1:0] cell_hit;
    logic [TABLE_ENTRIES-1:0] cell_fire;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready = 1'b0;
        commit     = 1'b0;
        case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_UPDATE: commit     = out_free;
            default: begin
                o_in_ready = 1'b0;
                commit     = 1'b0;
            end
        endcase
    end

    assign accept    = i_in_valid && o_in_ready;
    assign count_now = i_func || (i_new_addr < i_cur_addr);

    assign any_hit       = |cell_hit;
    assign any_fire      = |cell_fire;
    assign table_is_full = cell_valid[TABLE_ENTRIES-1];

    always_comb begin
        ctrl.capture  = accept;
        ctrl.count_it = count_now;
        ctrl.commit   = commit;
        ctrl.insert   = r_count_it && !any_hit;
        ctrl.thr_zero = (r_threshold == '0);
        n_full        = ctrl.insert && table_is_full;
        n_start       = any_fire || (ctrl.insert && !table_is_full && ctrl.thr_zero);
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            logic prev_valid;
            if (g == 0) begin : g_first
                assign prev_valid = 1'b1;
            end else begin : g_rest
                assign prev_valid = cell_valid[g-1];
            end
            htd_cell #(
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_new_addr   (i_new_addr),
                .i_upd_addr   (r_new_addr),
                .i_threshold  (r_threshold),
                .i_prev_valid (prev_valid),
                .o_valid      (cell_valid[g]),
                .o_hit        (cell_hit[g]),
                .o_fire       (cell_fire[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_threshold <= THRESH_RESET;
            r_count_it  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            if (accept) begin
                r_count_it <= count_now;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_new_addr <= i_new_addr;
        end
        if (commit) begin
            r_start      <= n_start;
            r_start_addr <= n_start ? r_new_addr : '0;
            r_full       <= n_full;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_start_recording = r_start;
    assign o_start_addr      = r_start_addr;
    assign o_table_full      = r_full;

endmodule

`default_nettype wire

FILE: tb/hot_trace_head_detector_tb.sv
// Self-checking testbench for hot_trace_head_detector: directed branches, a threshold
// far above any count the bench reaches and random branch streams with idling on both sides.
// Depends on htd_pkg and the design files under design/.
`timescale 1ns / 1ps

module hot_trace_head_detector_tb;
    import htd_pkg::*;

    localparam int CYCLE_LIMIT = 40_000;
    localparam int POOL_SIZE   = 96;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

    typedef struct {
        logic              start;
        logic [ADDR_W-1:0] addr;
        logic              full;
    } t_detection;

    // Shadow copy of the head table; predicts one detection per accepted branch.
    class detect_scoreboard;
        logic                      used  [TABLE_ENTRIES_DEF];
        logic [ADDR_W-1:0]         tag   [TABLE_ENTRIES_DEF];
        logic [COUNT_BITS_DEF-1:0] hits  [TABLE_ENTRIES_DEF];
        logic                      fired [TABLE_ENTRIES_DEF];
        logic [THRESH_W-1:0]       threshold;
        t_detection                pending_detections[$];
        int errors;
        int branches;
        int region_starts;
        int full_reports;

        function new();
            foreach (used[i]) begin
                used[i]  = 1'b0;
                tag[i]   = '0;
                hits[i]  = '0;
                fired[i] = 1'b0;
            end
            threshold = THRESH_RESET;
            errors = 0;
            branches = 0;
            region_starts = 0;
            full_reports = 0;
        endfunction

        function void set_threshold(logic [THRESH_W-1:0] value);
            threshold = value;
        endfunction

        function int pending_count();
            return pending_detections.size();
        endfunction

        function void note_branch(logic f, logic [ADDR_W-1:0] cur, logic [ADDR_W-1:0] tgt);
            t_detection d;
            logic counted;
            int slot;
            counted = f || (tgt < cur);
            slot = -1;
            d.start = 1'b0;
            d.addr  = '0;
            d.full  = 1'b0;
            foreach (used[i])
                if (slot < 0 && used[i] && tag[i] == tgt)
                    slot = i;
            if (counted) begin
                if (slot >= 0) begin
                    if (hits[slot] != COUNT_TOP)
                        hits[slot] = hits[slot] + 1'b1;
                end else begin
                    foreach (used[i])
                        if (slot < 0 && !used[i])
                            slot = i;
                    if (slot >= 0) begin
                        used[slot]  = 1'b1;
                        tag[slot]   = tgt;
                        hits[slot]  = '0;
                        fired[slot] = 1'b0;
                    end else begin
                        d.full = 1'b1;
                    end
                end
            end
            if (slot >= 0 && !fired[slot] && hits[slot] >= threshold) begin
                d.start = 1'b1;
                d.addr  = tgt;
                fired[slot] = 1'b1;
            end
            branches++;
            if (d.start) region_starts++;
            if (d.full) full_reports++;
            pending_detections.push_back(d);
        endfunction

        function void check_detection(logic st, logic [ADDR_W-1:0] a, logic fl);
            t_detection e;
            if (pending_detections.size() == 0) begin
                $error("unexpected result: start_recording=%0b start_addr=%h table_full=%0b",
                       st, a, fl);
                errors++;
                return;
            end
            e = pending_detections.pop_front();
            if (st !== e.start) begin
                $error("start_recording: expected %0b, actual %0b", e.start, st);
                errors++;
            end
            if (a !== e.addr) begin
                $error("start_addr: expected %h, actual %h", e.addr, a);
                errors++;
            end
            if (fl !== e.full) begin
                $error("table_full: expected %0b, actual %0b", e.full, fl);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [THRESH_W-1:0] cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic                func;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   new_addr;
    logic                out_valid;
    logic                out_ready;
    logic                start_recording;
    logic [ADDR_W-1:0]   start_addr;
    logic                table_full;

    detect_scoreboard  sb;
    logic [ADDR_W-1:0] target_pool [POOL_SIZE];
    int sender_gap_pct   = 0;
    int receiver_gap_pct = 0;
    int stall_request    = 0;
    int cycle_count      = 0;

    hot_trace_head_detector dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_func            (func),
        .i_cur_addr        (cur_addr),
        .i_new_addr        (new_addr),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_start_recording (start_recording),
        .o_start_addr      (start_addr),
        .o_table_full      (table_full)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("hot_trace_head_detector_tb: errors");
            $finish;
        end
    end

    // Result side: values read straight after the edge are those the edge saw.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready)
                sb.check_detection(start_recording, start_addr, table_full);
            if (stall_request > 0) begin
                hold_left = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= receiver_gap_pct);
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Picks a source address so that the branch to tgt goes backward or not.
    function automatic logic [ADDR_W-1:0] source_for(logic [ADDR_W-1:0] tgt, logic backward);
        if (tgt == '1)
            return rand64();
        if (backward)
            return tgt + 64'd1 + (rand64() % (~tgt));
        return rand64() % (tgt + 64'd1);
    endfunction

    task automatic send_branch(logic f, logic [ADDR_W-1:0] c, logic [ADDR_W-1:0] n);
        while ($urandom_range(99) < sender_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        cur_addr <= c;
        new_addr <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_branch(f, c, n);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THRESH_W-1:0] value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        sb.set_threshold(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly branches among a pool of hot targets; the rest are forward jumps
    // to random targets, which leave the table alone.
    task automatic run_branches(int items, int pool_span);
        int sent;
        logic f;
        logic back;
        logic [ADDR_W-1:0] n;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(99) < 15) begin
                n = rand64();
                send_branch(1'b0, source_for(n, 1'b0), n);
            end else begin
                n = target_pool[$urandom_range(pool_span - 1)];
                f = ($urandom_range(1) == 1);
                back = f ? ($urandom_range(1) == 1) : ($urandom_range(3) != 0);
                send_branch(f, source_for(n, back), n);
            end
            sent++;
        end
    endtask

    initial begin : main
        sb = new();
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func     <= 1'b0;
        cur_addr <= '0;
        new_addr <= '0;
        target_pool[0] = '0;
        target_pool[1] = '1;
        target_pool[2] = 64'h8000_0000_0000_0000;
        for (int i = 3; i < POOL_SIZE; i++)
            target_pool[i] = rand64();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold: inserts, a forward jump to an unknown target, equal addresses.
        send_branch(1'b1, '0, '0);
        send_branch(1'b0, '0, '1);
        send_branch(1'b0, '1, '0);
        send_branch(1'b0, 64'd5, 64'd5);
        send_branch(1'b1, '1, '1);

        // Threshold zero: forward visits to known entries fire, new entries fire at once.
        write_threshold('0);
        send_branch(1'b0, '0, '0);
        send_branch(1'b0, '0, '1);
        send_branch(1'b1, '0, '0);
        send_branch(1'b1, '0, 64'd1);
        send_branch(1'b0, 64'd1, 64'h5555_5555_5555_5555);

        write_threshold(16'd2);
        repeat (3) send_branch(1'b0, '1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_branch(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);

        // A threshold far above any count reached here: nothing may fire.
        write_threshold('1);
        repeat (8) send_branch(1'b1, rand64(), 64'h8000_0000_0000_0000);

        write_threshold(16'd3);
        sender_gap_pct   = 23;
        receiver_gap_pct = 67;
        run_branches(190, 40);

        write_threshold(16'd1);
        sender_gap_pct   = 67;
        receiver_gap_pct = 23;
        run_branches(190, 56);

        // The wider pool overflows the table; the long hold-off backs up the input.
        write_threshold(16'd8);
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
        stall_request    = 300;
        run_branches(190, POOL_SIZE);

        drain();
        repeat (20) @(posedge clk);
        if (sb.pending_count() != 0) begin
            $error("%0d expected results never arrived", sb.pending_count());
            sb.errors++;
        end
        $display("Covered %0d branches at thresholds 0 to 65535, with %0d region starts",
                 sb.branches, sb.region_starts);
        $display("and %0d table-full reports, with idling on both sides and a long hold-off.",
                 sb.full_reports);
        if (sb.errors == 0) begin
            $display("hot_trace_head_detector_tb: clean");
        end else begin
            $display("hot_trace_head_detector_tb: errors");
        end
        $finish;
    end

endmodule
